>>> rtl/taai_pkg.sv
package taai_pkg;

    localparam int ANGLE_W   = 16;
    localparam int WORD_W    = 32;
    localparam int FRAME_W   = 8;
    localparam int FRAC_BITS = 16;
    localparam int AXES      = 3;

    // input item kinds
    localparam logic KIND_SPAWN = 1'b0;
    localparam logic KIND_TICK  = 1'b1;

    // turn phases
    localparam logic [1:0] PH_IDLE  = 2'd0;
    localparam logic [1:0] PH_FIRST = 2'd1;
    localparam logic [1:0] PH_STEP  = 2'd2;
    localparam logic [1:0] PH_LAST  = 2'd3;

    // divider: quotient bits resolved per cycle
    localparam int DIV_DIGIT = 4;
    localparam int DIV_STEPS = WORD_W / DIV_DIGIT;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);

    localparam int IN_DATA_W  = 3 * ANGLE_W + 3 * WORD_W + FRAME_W;
    localparam int OUT_DATA_W = 56;

    typedef struct packed {
        logic              start;
        logic [WORD_W-1:0] dividend;
        logic [FRAME_W-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic              done;
        logic [WORD_W-1:0] quotient;
    } t_div_rsp;

endpackage

>>> rtl/taai_div.sv
module taai_div
    import taai_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_div_req i_req,
    output t_div_rsp o_rsp
);

    logic                 r_busy, n_busy;
    logic                 r_done, n_done;
    logic [DIV_CNT_W-1:0] r_cnt, n_cnt;
    logic [WORD_W-1:0]    r_shift, n_shift;
    logic [FRAME_W-1:0]   r_rem, n_rem;
    logic [FRAME_W-1:0]   r_div, n_div;

    // restoring division, DIV_DIGIT bits per cycle; quotient shifts in at the bottom
    always_comb begin
        logic [FRAME_W:0] trial;
        n_busy  = r_busy;
        n_done  = 1'b0;
        n_cnt   = r_cnt;
        n_shift = r_shift;
        n_rem   = r_rem;
        n_div   = r_div;
        trial   = '0;
        if (i_req.start) begin
            n_busy  = 1'b1;
            n_cnt   = '0;
            n_shift = i_req.dividend;
            n_rem   = '0;
            n_div   = i_req.divisor;
        end else if (r_busy) begin
            for (int k = 0; k < DIV_DIGIT; k++) begin
                trial   = {n_rem, n_shift[WORD_W-1]};
                n_shift = {n_shift[WORD_W-2:0], 1'b0};
                if (trial >= {1'b0, r_div}) begin
                    n_rem      = FRAME_W'(trial - {1'b0, r_div});
                    n_shift[0] = 1'b1;
                end else begin
                    n_rem = trial[FRAME_W-1:0];
                end
            end
            n_cnt = r_cnt + 1'b1;
            if (r_cnt == DIV_CNT_W'(DIV_STEPS - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
        r_cnt   <= n_cnt;
        r_shift <= n_shift;
        r_rem   <= n_rem;
        r_div   <= n_div;
    end

    assign o_rsp.done     = r_done;
    assign o_rsp.quotient = r_shift;

endmodule

>>> rtl/three_axis_angle_interpolator_core.sv
// Spawn items and plain ticks are handled in the idle state; the result is registered behind the input.
// The first tick of a turn with a nonzero frame count runs three 32/8 divisions through one
// shared divider, 4 quotient bits a cycle, one axis after another.
// One item at a time; input ready only in the idle state (no division or write-back) and while the output slot is free.
// Synchronous active-low reset: idle phase, angles zero, turning clear, no result pending.
module three_axis_angle_interpolator_core
    import taai_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s_axis_tvalid,
    output logic                  o_s_axis_tready,
    // start_x, start_y, start_z, goal_x, goal_y, goal_z, frame_count
    input  logic [IN_DATA_W-1:0]  i_s_axis_tdata,
    // kind
    input  logic                  i_s_axis_tuser,
    output logic                  o_m_axis_tvalid,
    input  logic                  i_m_axis_tready,
    // angle_x, angle_y, angle_z, turning, finished, divide_fault, zero pad
    output logic [OUT_DATA_W-1:0] o_m_axis_tdata
);

    localparam logic [1:0] S_IDLE      = 2'd0;
    localparam logic [1:0] S_DIV_START = 2'd1;
    localparam logic [1:0] S_DIV_WAIT  = 2'd2;
    localparam logic [1:0] S_WB        = 2'd3;

    logic [1:0]          r_state, n_state;
    logic [1:0]          r_axis, n_axis;
    logic [1:0]          r_phase, n_phase;
    logic [ANGLE_W-1:0]  r_cur  [AXES], n_cur  [AXES];
    logic [WORD_W-1:0]   r_goal [AXES], n_goal [AXES];
    logic [WORD_W-1:0]   r_acc  [AXES], n_acc  [AXES];
    logic [WORD_W-1:0]   r_inc  [AXES], n_inc  [AXES];
    logic [FRAME_W-1:0]  r_frames, n_frames;
    logic                r_turning, n_turning;
    logic                r_ovalid, n_ovalid;
    logic [OUT_DATA_W-1:0] r_odata, n_odata;

    t_div_req div_req;
    t_div_rsp div_rsp;

    logic               in_acc;
    logic               out_free;
    logic               out_load;
    logic               fin, flt;
    logic [ANGLE_W-1:0] sel_diff;
    logic               sel_neg;
    logic [ANGLE_W-1:0] sel_mag;
    logic [WORD_W-1:0]  step_sum [AXES];

    assign out_free        = !r_ovalid || i_m_axis_tready;
    assign o_s_axis_tready = (r_state == S_IDLE) && out_free;
    assign in_acc          = i_s_axis_tvalid && o_s_axis_tready;

    // (goal - angle) << 16 keeps only the low 16 bits of the difference
    assign sel_diff = r_goal[r_axis][ANGLE_W-1:0] - r_cur[r_axis];
    assign sel_neg  = sel_diff[ANGLE_W-1];
    assign sel_mag  = sel_neg ? ANGLE_W'(0 - sel_diff) : sel_diff;

    assign div_req.start    = (r_state == S_DIV_START);
    assign div_req.dividend = {sel_mag, {FRAC_BITS{1'b0}}};
    assign div_req.divisor  = r_frames;

    always_comb begin
        for (int i = 0; i < AXES; i++) begin
            step_sum[i] = r_acc[i] + r_inc[i];
        end
    end

    always_comb begin
        n_state   = r_state;
        n_axis    = r_axis;
        n_phase   = r_phase;
        n_cur     = r_cur;
        n_goal    = r_goal;
        n_acc     = r_acc;
        n_inc     = r_inc;
        n_frames  = r_frames;
        n_turning = r_turning;
        out_load  = 1'b0;
        fin       = 1'b0;
        flt       = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    if (i_s_axis_tuser == KIND_SPAWN) begin
                        for (int i = 0; i < AXES; i++) begin
                            n_cur[i]  = i_s_axis_tdata[i*ANGLE_W +: ANGLE_W];
                            n_goal[i] = i_s_axis_tdata[AXES*ANGLE_W + i*WORD_W +: WORD_W];
                        end
                        n_frames = i_s_axis_tdata[AXES*(ANGLE_W+WORD_W) +: FRAME_W];
                        n_phase  = PH_FIRST;
                        out_load = 1'b1;
                    end else begin
                        case (r_phase)
                            PH_FIRST: begin
                                if (r_frames == '0) begin
                                    flt      = 1'b1;
                                    n_phase  = PH_IDLE;
                                    out_load = 1'b1;
                                end else begin
                                    for (int i = 0; i < AXES; i++) begin
                                        n_acc[i] = {r_cur[i], {FRAC_BITS{1'b0}}};
                                    end
                                    n_axis  = '0;
                                    n_state = S_DIV_START;
                                end
                            end
                            PH_STEP: begin
                                if (r_frames == '0) begin
                                    n_phase = PH_LAST;
                                end else begin
                                    for (int i = 0; i < AXES; i++) begin
                                        n_acc[i] = step_sum[i];
                                        n_cur[i] = step_sum[i][WORD_W-1 -: ANGLE_W];
                                    end
                                    n_frames = r_frames - 1'b1;
                                end
                                out_load = 1'b1;
                            end
                            PH_LAST: begin
                                for (int i = 0; i < AXES; i++) begin
                                    n_cur[i] = r_goal[i][ANGLE_W-1:0];
                                end
                                n_turning = 1'b0;
                                fin       = 1'b1;
                                n_phase   = PH_IDLE;
                                out_load  = 1'b1;
                            end
                            default: begin
                                out_load = 1'b1;
                            end
                        endcase
                    end
                end
            end
            S_DIV_START: begin
                n_state = S_DIV_WAIT;
            end
            S_DIV_WAIT: begin
                if (div_rsp.done) begin
                    n_inc[r_axis] = sel_neg ? WORD_W'(0 - div_rsp.quotient)
                                            : div_rsp.quotient;
                    if (r_axis == 2'(AXES - 1)) begin
                        n_state = S_WB;
                    end else begin
                        n_axis  = r_axis + 1'b1;
                        n_state = S_DIV_START;
                    end
                end
            end
            S_WB: begin
                if (out_free) begin
                    n_turning = 1'b1;
                    n_phase   = PH_STEP;
                    out_load  = 1'b1;
                    n_state   = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        n_ovalid = r_ovalid && !i_m_axis_tready;
        n_odata  = r_odata;
        if (out_load) begin
            n_ovalid = 1'b1;
            n_odata  = {5'b0, flt, fin, n_turning, n_cur[2], n_cur[1], n_cur[0]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_phase   <= PH_IDLE;
            r_turning <= 1'b0;
            r_ovalid  <= 1'b0;
            for (int i = 0; i < AXES; i++) begin
                r_cur[i] <= '0;
            end
        end else begin
            r_state   <= n_state;
            r_phase   <= n_phase;
            r_turning <= n_turning;
            r_ovalid  <= n_ovalid;
            r_cur     <= n_cur;
        end
        r_axis   <= n_axis;
        r_goal   <= n_goal;
        r_acc    <= n_acc;
        r_inc    <= n_inc;
        r_frames <= n_frames;
        r_odata  <= n_odata;
    end

    taai_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    assign o_m_axis_tvalid = r_ovalid;
    assign o_m_axis_tdata  = r_odata;

endmodule

>>> tb/tb_top.sv
module tb_top;
    import taai_pkg::*;

    localparam int CLK_HALF     = 2;
    localparam int RAND_ITEMS   = 1800;
    localparam int CYCLE_LIMIT  = 1000000;
    localparam int DRAIN_CYCLES = 80;
    localparam int PRESS_AT     = 500;
    localparam int PRESS_LEN    = 400;

    typedef struct packed {
        logic                           kind;
        logic [FRAME_W-1:0]             frames;
        logic [AXES-1:0][WORD_W-1:0]    goal;
        logic [AXES-1:0][ANGLE_W-1:0]   start;
    } t_turn_item;

    typedef struct packed {
        logic                           fault;
        logic                           fin;
        logic                           turning;
        logic [AXES-1:0][ANGLE_W-1:0]   ang;
    } t_pose;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_s_axis_tvalid = 1'b0;
    logic                  o_s_axis_tready;
    // start_x, start_y, start_z, goal_x, goal_y, goal_z, frame_count
    logic [IN_DATA_W-1:0]  i_s_axis_tdata = '0;
    // kind
    logic                  i_s_axis_tuser = 1'b0;
    logic                  o_m_axis_tvalid;
    logic                  i_m_axis_tready = 1'b0;
    // angle_x, angle_y, angle_z, turning, finished, divide_fault, zero pad
    logic [OUT_DATA_W-1:0] o_m_axis_tdata;

    three_axis_angle_interpolator_core DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

    always #CLK_HALF i_clk = ~i_clk;

    t_turn_item pend_items[$];
    t_pose      pose_expect_q[$];
    t_turn_item tx_item = '0;
    int         tx_gap = 0;
    int         tx_mode = 1;
    int         rx_hold = 0;
    int         rx_mode = 1;
    int         rx_count = 0;
    int         press_left = 0;
    logic       press_done = 1'b0;
    int         err_count = 0;
    int         cycle_count = 0;

    // predictor state, reset values
    logic [1:0]                   turn_phase = PH_IDLE;
    logic [AXES-1:0][WORD_W-1:0]  accum = '0;
    logic [AXES-1:0][WORD_W-1:0]  step_w = '0;
    logic [AXES-1:0][WORD_W-1:0]  goal_w = '0;
    logic [AXES-1:0][ANGLE_W-1:0] cur_ang = '0;
    logic [FRAME_W-1:0]           frames_left = '0;
    logic                         turning_q = 1'b0;

    task automatic advance_camera(input t_turn_item it);
        t_pose       r;
        logic [31:0] a;
        logic [31:0] diff;
        int          q;
        r = '0;
        if (it.kind == KIND_SPAWN) begin
            cur_ang     = it.start;
            goal_w      = it.goal;
            frames_left = it.frames;
            turn_phase  = PH_FIRST;
        end else begin
            case (turn_phase)
                PH_FIRST: begin
                    if (frames_left == 0) begin
                        r.fault    = 1'b1;
                        turn_phase = PH_IDLE;
                    end else begin
                        for (int i = 0; i < AXES; i++) begin
                            a         = {{16{cur_ang[i][15]}}, cur_ang[i]};
                            diff      = (goal_w[i] - a) << FRAC_BITS;
                            accum[i]  = a << FRAC_BITS;
                            // int division truncates toward zero
                            q         = $signed(diff) / int'(frames_left);
                            step_w[i] = q;
                        end
                        turning_q  = 1'b1;
                        turn_phase = PH_STEP;
                    end
                end
                PH_STEP: begin
                    if (frames_left == 0) begin
                        turn_phase = PH_LAST;
                    end else begin
                        for (int i = 0; i < AXES; i++) begin
                            accum[i]   = accum[i] + step_w[i];
                            cur_ang[i] = accum[i][31:16];
                        end
                        frames_left = frames_left - 1'b1;
                    end
                end
                PH_LAST: begin
                    for (int i = 0; i < AXES; i++) cur_ang[i] = goal_w[i][15:0];
                    turning_q  = 1'b0;
                    r.fin      = 1'b1;
                    turn_phase = PH_IDLE;
                end
                default: ;
            endcase
        end
        r.ang     = cur_ang;
        r.turning = turning_q;
        pose_expect_q.push_back(r);
    endtask

    function automatic int idle_draw(input int mode);
        case (mode)
            0:       return 0;
            1:       return $urandom_range(0, 16);
            default: return ($urandom_range(0, 7) == 0) ? $urandom_range(0, 16) : 0;
        endcase
    endfunction

    function automatic t_turn_item make_tick();
        t_turn_item it;
        // fields other than kind are don't-care on a tick
        it.start  = 48'({$urandom, $urandom});
        it.goal   = {$urandom, $urandom, $urandom};
        it.frames = 8'($urandom);
        it.kind   = KIND_TICK;
        return it;
    endfunction

    function automatic t_turn_item make_spawn(input logic [15:0] sx, sy, sz,
                                              input logic [31:0] gx, gy, gz,
                                              input logic [7:0] n);
        t_turn_item it;
        it.kind   = KIND_SPAWN;
        it.start  = {sz, sy, sx};
        it.goal   = {gz, gy, gx};
        it.frames = n;
        return it;
    endfunction

    function automatic logic [31:0] pick_goal(input logic [15:0] s);
        if ($urandom_range(0, 1) == 0) return $urandom;
        return {{16{s[15]}}, s} + 32'($signed($urandom_range(0, 4000)) - 2000);
    endfunction

    // spawn plus stop_at ticks; n+3 ticks complete the turn, stop_at < n+3 leaves it open
    task automatic queue_turn(input int n, input int stop_at);
        logic [2:0][15:0] s;
        s = 48'({$urandom, $urandom});
        pend_items.push_back(make_spawn(s[0], s[1], s[2], pick_goal(s[0]),
                                        pick_goal(s[1]), pick_goal(s[2]), 8'(n)));
        for (int k = 0; k < stop_at; k++) pend_items.push_back(make_tick());
    endtask

    task automatic check_field(input string name, input logic [15:0] exp_v,
                               input logic [15:0] act_v);
        if (exp_v !== act_v) begin
            $display("%0t: %s mismatch: expected %h, actual %h", $time, name, exp_v, act_v);
            err_count++;
        end
    endtask

    // sender
    always @(posedge i_clk) begin : drv
        logic hs;
        int   g;
        if (!i_rst_n) begin
            i_s_axis_tvalid <= 1'b0;
            tx_gap          <= 0;
        end else begin
            hs = i_s_axis_tvalid && o_s_axis_tready;
            g  = tx_gap;
            if (hs) begin
                advance_camera(tx_item);
                if ($urandom_range(0, 99) == 0) tx_mode = $urandom_range(0, 2);
                g = idle_draw(tx_mode);
            end
            if (i_s_axis_tvalid && !hs) begin
                // hold the item
            end else if (g != 0) begin
                i_s_axis_tvalid <= 1'b0;
                tx_gap          <= g - 1;
            end else if (pend_items.size() != 0) begin
                tx_item         <= pend_items[0];
                i_s_axis_tdata  <= {pend_items[0].frames, pend_items[0].goal,
                                    pend_items[0].start};
                i_s_axis_tuser  <= pend_items[0].kind;
                i_s_axis_tvalid <= 1'b1;
                tx_gap          <= 0;
                void'(pend_items.pop_front());
            end else begin
                i_s_axis_tvalid <= 1'b0;
                tx_gap          <= 0;
            end
        end
    end

    // receiver and checker
    always @(posedge i_clk) begin : mon
        t_pose act, exp_p;
        int    w;
        if (!i_rst_n) begin
            i_m_axis_tready <= 1'b0;
            rx_hold         <= 0;
        end else begin
            w = rx_hold;
            if (o_m_axis_tvalid && i_m_axis_tready) begin
                act.ang     = o_m_axis_tdata[47:0];
                act.turning = o_m_axis_tdata[48];
                act.fin     = o_m_axis_tdata[49];
                act.fault   = o_m_axis_tdata[50];
                if (pose_expect_q.size() == 0) begin
                    $display("%0t: unexpected item: expected none, actual %h",
                             $time, o_m_axis_tdata);
                    err_count++;
                end else begin
                    exp_p = pose_expect_q.pop_front();
                    check_field("angle_x", exp_p.ang[0], act.ang[0]);
                    check_field("angle_y", exp_p.ang[1], act.ang[1]);
                    check_field("angle_z", exp_p.ang[2], act.ang[2]);
                    check_field("turning", 16'(exp_p.turning), 16'(act.turning));
                    check_field("finished", 16'(exp_p.fin), 16'(act.fin));
                    check_field("divide_fault", 16'(exp_p.fault), 16'(act.fault));
                end
                rx_count <= rx_count + 1;
                if ($urandom_range(0, 99) == 0) rx_mode = $urandom_range(0, 2);
                w = idle_draw(rx_mode);
            end
            if (w != 0) begin
                i_m_axis_tready <= 1'b0;
                rx_hold         <= w - 1;
            end else begin
                i_m_axis_tready <= (press_left == 0);
                rx_hold         <= 0;
            end
        end
    end

    // one long receiver hold-off so the block backs up into its input
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            press_left <= 0;
        end else if (rx_count == PRESS_AT && !press_done) begin
            press_left <= PRESS_LEN;
            press_done <= 1'b1;
        end else if (press_left != 0) begin
            press_left <= press_left - 1;
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    initial begin : stim
        int base;
        int r;
        int n;
        int stop_at;

        // tick while idle straight out of reset
        pend_items.push_back(make_tick());
        // extreme angles and goals, single-frame turn run to completion
        pend_items.push_back(make_spawn(16'h8000, 16'h7fff, 16'h0000,
                                        32'h7fffffff, 32'h80000000, 32'hffffffff, 8'd1));
        repeat (4) pend_items.push_back(make_tick());
        pend_items.push_back(make_tick());
        // zero frame count: divide fault, back to idle
        pend_items.push_back(make_spawn(16'h1234, 16'hfedc, 16'h8000,
                                        32'h00010000, 32'hffff0000, 32'h00007fff, 8'd0));
        repeat (2) pend_items.push_back(make_tick());
        // longest turn, restarted by a spawn mid-turn (turning stays set)
        pend_items.push_back(make_spawn(16'h7fff, 16'h8000, 16'hffff,
                                        32'h80000000, 32'h7fffffff, 32'h00000000, 8'd255));
        repeat (2) pend_items.push_back(make_tick());
        pend_items.push_back(make_spawn(16'h0100, 16'hff00, 16'h0001,
                                        32'hffff8000, 32'h00007fff, 32'hdeadbeef, 8'd2));
        repeat (5) pend_items.push_back(make_tick());
        // two spawns back to back, then a three-frame turn
        pend_items.push_back(make_spawn(16'h5555, 16'haaaa, 16'h0f0f,
                                        32'h12345678, 32'h9abcdef0, 32'h0000ffff, 8'd7));
        pend_items.push_back(make_spawn(16'haaaa, 16'h5555, 16'hf0f0,
                                        32'hffffffff, 32'h00000001, 32'h80008000, 8'd3));
        repeat (6) pend_items.push_back(make_tick());

        base = pend_items.size();
        while (pend_items.size() - base < RAND_ITEMS) begin
            r = $urandom_range(0, 99);
            if (r < 72) begin
                r = $urandom_range(0, 99);
                if (r < 85)      n = $urandom_range(1, 12);
                else if (r < 95) n = $urandom_range(13, 60);
                else             n = $urandom_range(128, 255);
                stop_at = n + 3;
                if ($urandom_range(0, 4) == 0) stop_at = $urandom_range(0, n + 2);
                queue_turn(n, stop_at);
            end else if (r < 80) begin
                queue_turn(0, $urandom_range(1, 2));
            end else if (r < 90) begin
                repeat ($urandom_range(1, 3)) pend_items.push_back(make_tick());
            end else begin
                // noise: spawn with arbitrary frame count, few ticks
                pend_items.push_back(make_spawn(16'($urandom), 16'($urandom),
                                                16'($urandom), $urandom, $urandom,
                                                $urandom, 8'($urandom)));
                repeat ($urandom_range(0, 3)) pend_items.push_back(make_tick());
            end
        end

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (pend_items.size() != 0 || i_s_axis_tvalid) @(posedge i_clk);
        while (pose_expect_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (err_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
